FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the shell word splitter, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("concurrent assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: rtl/swsp_pkg.sv
// Package with the types, constants and helpers of the shell word splitter.
package swsp_pkg;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   typedef struct packed {
      logic        last;
      logic [15:0] word_count;
      logic        quote_error;
      logic        line_end;
      logic        word_end;
      logic        byte_valid;
      logic [7:0]  out_byte;
   } swsp_rsp_type;

   typedef struct packed {
      logic [1:0]   count;
      swsp_rsp_type res1;
      swsp_rsp_type res0;
   } swsp_lex_out_type;

   function automatic swsp_rsp_type rsp_byte(input logic [7:0] value);
      swsp_rsp_type r;
      r            = '0;
      r.out_byte   = value;
      r.byte_valid = 1'b1;
      return r;
   endfunction

endpackage

FILE: rtl/shell_word_splitter.sv
// Top level of the shell word splitter: input register, lexer and result queue.
// Each byte goes from the input register through the lexer into the result queue.
// Throughput: one byte per cycle; the four-entry result queue absorbs the byte that
// yields two results, and the input register holds while the queue lacks room for them.
// Reset: synchronous and active high; clears the lexer state and empties both stages.
module shell_word_splitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [23:8] word_count
   output logic [3:0]  rsp_tuser,   // [0] byte_valid, [1] word_end, [2] line_end, [3] quote_error
   output logic        rsp_tlast
);
   import swsp_pkg::*;
   `include "assert_macros.svh"

   logic                  in_valid_ff;
   logic [7:0]            in_ch_ff;
   logic                  consume;
   logic                  load;
   swsp_lex_out_type      lex_out;
   swsp_rsp_type          head;
   logic [FIFO_CNT_W-1:0] free;

   assign consume    = in_valid_ff && (FIFO_CNT_W'(lex_out.count) <= free);
   assign req_tready = !in_valid_ff || consume;
   assign load       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (load) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_ch_ff <= req_tdata;
      end
   end

   swsp_lexer u_lexer (
      .clock   (clock),
      .reset   (reset),
      .ch      (in_ch_ff),
      .fire    (consume),
      .lex_out (lex_out)
   );

   swsp_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_n     (consume ? lex_out.count : 2'd0),
      .push_d0    (lex_out.res0),
      .push_d1    (lex_out.res1),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_data  (head),
      .free       (free)
   );

   assign rsp_tdata = {head.word_count, head.out_byte};
   assign rsp_tuser = {head.quote_error, head.line_end, head.word_end, head.byte_valid};
   assign rsp_tlast = head.last;

   `ASSERT_CLK(a_hold_input, clock, reset, in_valid_ff && !consume |=> in_valid_ff && $stable(in_ch_ff))
   `ASSERT_CLK(a_line_end_last, clock, reset, rsp_tvalid && head.line_end |-> head.last)
   `ASSERT_NEVER(a_error_no_count, clock, reset, rsp_tvalid && head.quote_error && (head.word_end || head.word_count != 16'd0))
   `ASSERT_NEVER(a_byte_no_mark, clock, reset, rsp_tvalid && head.byte_valid && (head.word_end || head.line_end))

endmodule

FILE: rtl/swsp_lexer.sv
// Lexer state and the combinational decode of one byte into up to two results.
module swsp_lexer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 ch,
   input  logic                       fire,
   output swsp_pkg::swsp_lex_out_type lex_out
);
   import swsp_pkg::*;

   typedef enum logic [1:0] {MODE_GAP, MODE_WORD, MODE_SQ, MODE_DQ} lex_mode_type;

   lex_mode_type mode_ff, mode_in;
   logic         escape_ff, escape_in;
   logic [15:0]  words_ff, words_in;

   swsp_rsp_type res [2];
   logic [1:0]   n;
   logic         done;
   logic         is_gap;
   logic [15:0]  words_inc;

   assign is_gap    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
   assign words_inc = (words_ff == 16'hFFFF) ? words_ff : words_ff + 16'd1;

   always_comb begin
      res[0]    = '0;
      res[1]    = '0;
      n         = 2'd0;
      done      = 1'b0;
      mode_in   = mode_ff;
      escape_in = escape_ff;
      words_in  = words_ff;

      if (ch == CH_NUL) begin
         if (escape_ff) begin
            res[0] = rsp_byte(CH_BSLASH);
            n      = 2'd1;
         end
         res[n[0]].line_end = 1'b1;
         if (mode_ff == MODE_SQ || mode_ff == MODE_DQ) begin
            res[n[0]].quote_error = 1'b1;
         end else if (mode_ff == MODE_WORD) begin
            res[n[0]].word_end   = 1'b1;
            res[n[0]].word_count = words_inc;
         end else begin
            res[n[0]].word_count = words_ff;
         end
         n         = n + 2'd1;
         mode_in   = MODE_GAP;
         escape_in = 1'b0;
         words_in  = '0;
      end else begin
         if (escape_ff) begin
            escape_in = 1'b0;
            if (mode_ff == MODE_DQ && ch != CH_DQUOTE && ch != CH_BSLASH && ch != CH_DOLLAR) begin
               res[0] = rsp_byte(CH_BSLASH);
               n      = 2'd1;
            end else begin
               res[0] = rsp_byte(ch);
               n      = 2'd1;
               done   = 1'b1;
            end
         end
         if (!done) begin
            unique case (mode_ff)
               MODE_GAP: begin
                  if (is_gap) begin
                     mode_in = MODE_GAP;
                  end else if (ch == CH_SQUOTE) begin
                     mode_in = MODE_SQ;
                  end else if (ch == CH_DQUOTE) begin
                     mode_in = MODE_DQ;
                  end else if (ch == CH_BSLASH) begin
                     mode_in   = MODE_WORD;
                     escape_in = 1'b1;
                  end else begin
                     mode_in    = MODE_WORD;
                     res[n[0]]  = rsp_byte(ch);
                     n          = n + 2'd1;
                  end
               end
               MODE_WORD: begin
                  if (is_gap) begin
                     words_in           = words_inc;
                     mode_in            = MODE_GAP;
                     res[n[0]].word_end = 1'b1;
                     n                  = n + 2'd1;
                  end else if (ch == CH_SQUOTE) begin
                     mode_in = MODE_SQ;
                  end else if (ch == CH_DQUOTE) begin
                     mode_in = MODE_DQ;
                  end else if (ch == CH_BSLASH) begin
                     escape_in = 1'b1;
                  end else begin
                     res[n[0]] = rsp_byte(ch);
                     n         = n + 2'd1;
                  end
               end
               MODE_SQ: begin
                  if (ch == CH_SQUOTE) begin
                     mode_in = MODE_WORD;
                  end else begin
                     res[n[0]] = rsp_byte(ch);
                     n         = n + 2'd1;
                  end
               end
               MODE_DQ: begin
                  if (ch == CH_DQUOTE) begin
                     mode_in = MODE_WORD;
                  end else if (ch == CH_BSLASH) begin
                     escape_in = 1'b1;
                  end else begin
                     res[n[0]] = rsp_byte(ch);
                     n         = n + 2'd1;
                  end
               end
               default: begin
                  mode_in = MODE_GAP;
               end
            endcase
         end
      end

      if (n != 2'd0) begin
         res[n[1]].last = 1'b1;
      end
   end

   assign lex_out.count = n;
   assign lex_out.res0  = res[0];
   assign lex_out.res1  = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_GAP;
         escape_ff <= 1'b0;
         words_ff  <= '0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         escape_ff <= escape_in;
         words_ff  <= words_in;
      end
   end

endmodule

FILE: rtl/swsp_rsp_fifo.sv
// Result queue that takes up to two results per cycle and hands out one.
module swsp_rsp_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [1:0]                           push_n,
   input  swsp_pkg::swsp_rsp_type               push_d0,
   input  swsp_pkg::swsp_rsp_type               push_d1,
   input  logic                                 pop,
   output logic                                 head_valid,
   output swsp_pkg::swsp_rsp_type               head_data,
   output logic [swsp_pkg::FIFO_CNT_W-1:0]      free
);
   import swsp_pkg::*;

   swsp_rsp_type            entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic [FIFO_PTR_W-1:0]   wr_ptr_next;
   logic                    do_pop;

   assign do_pop      = pop && (count_ff != '0);
   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);
   assign head_valid  = (count_ff != '0);
   assign head_data   = entries_ff[rd_ptr_ff];
   assign free        = FIFO_CNT_W'(FIFO_DEPTH) - count_ff;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_d0;
      end
      if (push_n == 2'd2) begin
         entries_ff[wr_ptr_next] <= push_d1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(do_pop);
         count_ff  <= count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(do_pop);
      end
   end

endmodule

FILE: tb/tb_shell_word_splitter.sv
// Self-checking testbench for the shell word splitter, with a directed script and random command lines.
`timescale 1ns / 1ps

module tb_shell_word_splitter;
   import swsp_pkg::*;

   localparam int unsigned RUN_LIMIT = 3_000_000;
   localparam int unsigned RANDOM_ITEMS = 850;

   typedef enum logic [1:0] {LX_GAP, LX_WORD, LX_SQUOTE, LX_DQUOTE} lex_state_t;

   typedef struct {
      logic [7:0]   ch;
      bit           typed;
      swsp_rsp_type res;
   } script_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   lex_state_t   lex = LX_GAP;
   bit           esc_pend = 1'b0;
   logic [15:0]  word_tally = '0;
   swsp_rsp_type due_tokens [$];
   script_row_t  script [$];
   logic [7:0]   line_bytes [$];
   bit           calm = 1'b0;
   int unsigned  errors = 0;
   int unsigned  cycles = 0;
   int unsigned  fed = 0;

   shell_word_splitter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic bit is_special(input logic [7:0] c);
      return c == CH_BSLASH || c == CH_SQUOTE || c == CH_DQUOTE || c == CH_DOLLAR ||
             is_blank(c);
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic swsp_rsp_type byte_res(input logic [7:0] c);
      swsp_rsp_type r;
      r            = '0;
      r.out_byte   = c;
      r.byte_valid = 1'b1;
      return r;
   endfunction

   function automatic swsp_rsp_type line_close(input bit qe, input logic [15:0] cnt);
      swsp_rsp_type r;
      r             = '0;
      r.line_end    = 1'b1;
      r.quote_error = qe;
      r.word_count  = cnt;
      r.last        = 1'b1;
      return r;
   endfunction

   function automatic void add_step(input logic [7:0] c, input bit typed = 1'b0,
                                    input swsp_rsp_type r = '0);
      script_row_t row;
      row.ch    = c;
      row.typed = typed;
      row.res   = r;
      script.push_back(row);
   endfunction

   function automatic logic [7:0] rand_any();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] rand_plain();
      logic [7:0] c;
      do c = rand_any(); while (is_special(c));
      return c;
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   function automatic logic [7:0] rand_special();
      case ($urandom_range(0, 4))
         0: return CH_BSLASH;
         1: return CH_SQUOTE;
         2: return CH_DQUOTE;
         3: return CH_DOLLAR;
         default: return rand_blank();
      endcase
   endfunction

   task automatic split_byte(input logic [7:0] ch);
      swsp_rsp_type res [2];
      int n;
      bit done;
      n      = 0;
      done   = 1'b0;
      res[0] = '0;
      res[1] = '0;
      if (ch == CH_NUL) begin
         if (esc_pend) begin
            res[n] = byte_res(CH_BSLASH);
            n++;
         end
         res[n]          = '0;
         res[n].line_end = 1'b1;
         if (lex == LX_SQUOTE || lex == LX_DQUOTE) begin
            res[n].quote_error = 1'b1;
         end else if (lex == LX_WORD) begin
            res[n].word_end   = 1'b1;
            res[n].word_count = sat_inc(word_tally);
         end else begin
            res[n].word_count = word_tally;
         end
         n++;
         lex        = LX_GAP;
         esc_pend   = 1'b0;
         word_tally = '0;
         done       = 1'b1;
      end else if (esc_pend) begin
         esc_pend = 1'b0;
         if (lex == LX_DQUOTE && ch != CH_DQUOTE && ch != CH_BSLASH && ch != CH_DOLLAR) begin
            res[n] = byte_res(CH_BSLASH);
            n++;
         end else begin
            res[n] = byte_res(ch);
            n++;
            done = 1'b1;
         end
      end
      if (!done) begin
         case (lex)
            LX_GAP: begin
               if (is_blank(ch)) begin
               end else if (ch == CH_SQUOTE) begin
                  lex = LX_SQUOTE;
               end else if (ch == CH_DQUOTE) begin
                  lex = LX_DQUOTE;
               end else if (ch == CH_BSLASH) begin
                  lex      = LX_WORD;
                  esc_pend = 1'b1;
               end else begin
                  lex    = LX_WORD;
                  res[n] = byte_res(ch);
                  n++;
               end
            end
            LX_WORD: begin
               if (is_blank(ch)) begin
                  word_tally      = sat_inc(word_tally);
                  lex             = LX_GAP;
                  res[n]          = '0;
                  res[n].word_end = 1'b1;
                  n++;
               end else if (ch == CH_SQUOTE) begin
                  lex = LX_SQUOTE;
               end else if (ch == CH_DQUOTE) begin
                  lex = LX_DQUOTE;
               end else if (ch == CH_BSLASH) begin
                  esc_pend = 1'b1;
               end else begin
                  res[n] = byte_res(ch);
                  n++;
               end
            end
            LX_SQUOTE: begin
               if (ch == CH_SQUOTE) begin
                  lex = LX_WORD;
               end else begin
                  res[n] = byte_res(ch);
                  n++;
               end
            end
            default: begin
               if (ch == CH_DQUOTE) begin
                  lex = LX_WORD;
               end else if (ch == CH_BSLASH) begin
                  esc_pend = 1'b1;
               end else begin
                  res[n] = byte_res(ch);
                  n++;
               end
            end
         endcase
      end
      if (n > 0) begin
         res[n-1].last = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
         due_tokens.push_back(res[k]);
      end
   endtask

   // Entered and left at a falling edge.
   task automatic feed(input logic [7:0] ch, input bit typed = 1'b0,
                       input swsp_rsp_type typed_res = '0);
      bit taken;
      int unsigned held;
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_tready;
         @(negedge clock);
      end
      held = due_tokens.size();
      split_byte(ch);
      if (typed) begin
         while (due_tokens.size() > held) begin
            void'(due_tokens.pop_back());
         end
         due_tokens.push_back(typed_res);
      end
   endtask

   task automatic build_line();
      int words;
      logic [7:0] c;
      line_bytes.delete();
      if ($urandom_range(99) < 80) begin
         words = $urandom_range(0, 6);
         repeat ($urandom_range(0, 2)) line_bytes.push_back(rand_blank());
         for (int w = 0; w < words; w++) begin
            if (w > 0) begin
               repeat ($urandom_range(1, 3)) line_bytes.push_back(rand_blank());
            end
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 4))
                  0, 1: begin
                     repeat ($urandom_range(1, 4)) line_bytes.push_back(rand_plain());
                  end
                  2: begin
                     line_bytes.push_back(CH_SQUOTE);
                     repeat ($urandom_range(0, 4)) begin
                        do c = rand_any(); while (c == CH_SQUOTE);
                        line_bytes.push_back(c);
                     end
                     line_bytes.push_back(CH_SQUOTE);
                  end
                  3: begin
                     line_bytes.push_back(CH_DQUOTE);
                     repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 2) == 0) begin
                           line_bytes.push_back(CH_BSLASH);
                           line_bytes.push_back(rand_any());
                        end else begin
                           do c = rand_any(); while (c == CH_DQUOTE || c == CH_BSLASH);
                           line_bytes.push_back(c);
                        end
                     end
                     line_bytes.push_back(CH_DQUOTE);
                  end
                  default: begin
                     line_bytes.push_back(CH_BSLASH);
                     line_bytes.push_back(rand_any());
                  end
               endcase
            end
         end
         if ($urandom_range(0, 1) == 1) begin
            line_bytes.push_back(rand_blank());
         end
         if ($urandom_range(0, 9) == 0) begin
            line_bytes.push_back(CH_BSLASH);
         end
      end else begin
         repeat ($urandom_range(0, 15)) begin
            line_bytes.push_back($urandom_range(0, 1) ? rand_any() : rand_special());
         end
      end
      line_bytes.push_back(CH_NUL);
   endtask

   always @(negedge clock) begin
      rsp_tready <= !reset && (calm || $urandom_range(99) >= 31);
   end

   always @(posedge clock) begin
      swsp_rsp_type got;
      swsp_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.last        = rsp_tlast;
         got.word_count  = rsp_tdata[23:8];
         got.quote_error = rsp_tuser[3];
         got.line_end    = rsp_tuser[2];
         got.word_end    = rsp_tuser[1];
         got.byte_valid  = rsp_tuser[0];
         got.out_byte    = rsp_tdata[7:0];
         if (due_tokens.size() == 0) begin
            $error("unexpected transaction: tdata %h tuser %h tlast %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want = due_tokens.pop_front();
            if (got !== want) begin
               errors++;
            end
            if (got.out_byte !== want.out_byte)
               $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            if (got.byte_valid !== want.byte_valid)
               $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
            if (got.word_end !== want.word_end)
               $error("word_end: expected %b, got %b", want.word_end, got.word_end);
            if (got.line_end !== want.line_end)
               $error("line_end: expected %b, got %b", want.line_end, got.line_end);
            if (got.quote_error !== want.quote_error)
               $error("quote_error: expected %b, got %b", want.quote_error, got.quote_error);
            if (got.word_count !== want.word_count)
               $error("word_count: expected %0d, got %0d", want.word_count, got.word_count);
            if (got.last !== want.last)
               $error("last: expected %b, got %b", want.last, got.last);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      add_step(CH_NUL, 1'b1, line_close(1'b0, 16'd0));
      add_step(8'h01);
      add_step(8'hFF);
      add_step(CH_SPACE);
      add_step(CH_SQUOTE);
      add_step(CH_SQUOTE);
      add_step(CH_TAB);
      add_step(CH_DQUOTE);
      add_step(CH_BSLASH);
      add_step(8'h6E);
      add_step(CH_BSLASH);
      add_step(CH_DOLLAR);
      add_step(CH_BSLASH);
      add_step(CH_DQUOTE);
      add_step(CH_DQUOTE);
      add_step(CH_BSLASH);
      add_step(CH_SPACE);
      add_step(CH_CR);
      add_step(CH_SQUOTE);
      add_step(CH_BSLASH);
      add_step(CH_NUL, 1'b1, line_close(1'b1, 16'd0));
      add_step(CH_LF);
      add_step(CH_BSLASH);
      add_step(CH_NUL);
      add_step(CH_DQUOTE);
      add_step(CH_NUL, 1'b1, line_close(1'b1, 16'd0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         feed(script[i].ch, script[i].typed, script[i].res);
      end

      while (fed < RANDOM_ITEMS) begin
         calm = (fed >= 300 && fed < 450);
         build_line();
         foreach (line_bytes[i]) begin
            feed(line_bytes[i]);
            fed++;
         end
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      while (due_tokens.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/swsp_pkg.sv
rtl/swsp_lexer.sv
rtl/swsp_rsp_fifo.sv
rtl/shell_word_splitter.sv
tb/tb_shell_word_splitter.sv
